// File: sv/tdpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the trial-division primality tester.
package tdpt_pkg;

	// Default width of the tested value.
	localparam int unsigned TDPT_VALUE_WIDTH = 31;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_LAUNCH = 2'd1,
		ST_WAIT   = 2'd2
	} tdpt_state_t;

endpackage

// File: sv/tdpt_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider that produces one quotient bit per cycle.
module tdpt_div #(
	parameter int unsigned DIVIDEND_W = tdpt_pkg::TDPT_VALUE_WIDTH,
	parameter int unsigned DIVISOR_W  = (tdpt_pkg::TDPT_VALUE_WIDTH + 2) / 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  active_q;
	logic                  done_q;
	logic [CNT_W-1:0]      count_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  div_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;
	logic [DIVISOR_W-1:0]  rem_next;

	// The partial remainder always stays below the divisor, so the trial value
	// is below twice the divisor and one subtract settles each bit.
	always_comb begin
		trial    = {rem_q, quo_q[DIVIDEND_W-1]};
		diff     = trial - {1'b0, div_q};
		fits     = (trial >= {1'b0, div_q});
		rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			count_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				count_q  <= CNT_W'(DIVIDEND_W);
			end else if (active_q) begin
				count_q <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (active_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: sv/trial_division_prime_test.sv
`timescale 1ns / 1ps
// Top level of the trial-division primality tester: sequencer and datapath.
// Candidates below 2 and even candidates give their result in the cycle after the
// transaction; odd candidates of 3 or more run one division per odd trial divisor on the
// shared divider, which yields one quotient bit per cycle.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset: arst_n low clears the sequencer, busy and the done strobe at once.
// The result is shown for one cycle on done; the receiver cannot stall it.
module trial_division_prime_test #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] candidate,
	output logic                   busy,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] tested_value,
	output logic                   is_prime
);

	// The divisor never passes the square root of the largest value by more
	// than two, which this width holds with room to spare.
	localparam int unsigned DIV_W = (VALUE_WIDTH + 2) / 2;

	localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(3);
	localparam logic [DIV_W-1:0] DIVISOR_STEP  = DIV_W'(2);
	localparam logic [VALUE_WIDTH-1:0] TWO     = VALUE_WIDTH'(2);

	tdpt_pkg::tdpt_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] held_candidate_q;
	logic [DIV_W-1:0]       trial_divisor_q;
	logic                   done_q;
	logic                   is_prime_q;

	logic                   accept;
	logic                   trivial;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [DIV_W-1:0]       div_remainder;
	logic                   past_root;
	logic                   divides;

	// The shared divider computes quotient and remainder together, so one
	// pass settles both the square bound and the divisibility check.
	tdpt_div #(
		.DIVIDEND_W(VALUE_WIDTH),
		.DIVISOR_W (DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (held_candidate_q),
		.divisor  (trial_divisor_q),
		.done     (div_done),
		.quotient (div_quotient),
		.remainder(div_remainder)
	);

	assign accept = start && (state_q == tdpt_pkg::ST_IDLE);

	// Zero, one and every even number are answered without any division.
	assign trivial = (candidate < TWO) || !candidate[0];

	// The divisor has passed the square root once it exceeds the quotient,
	// which is the same test as d*d > n without forming the product.
	assign past_root = (VALUE_WIDTH'(trial_divisor_q) > div_quotient);
	assign divides   = (div_remainder == '0);

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				if (accept && !trivial) begin
					state_d = tdpt_pkg::ST_LAUNCH;
				end
			end
			tdpt_pkg::ST_LAUNCH: begin
				state_d = tdpt_pkg::ST_WAIT;
			end
			tdpt_pkg::ST_WAIT: begin
				if (div_done) begin
					if (past_root || divides) begin
						state_d = tdpt_pkg::ST_IDLE;
					end else begin
						state_d = tdpt_pkg::ST_LAUNCH;
					end
				end
			end
			default: begin
				state_d = tdpt_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		div_start = 1'b0;
		busy      = 1'b1;
		case (state_q)
			tdpt_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			tdpt_pkg::ST_LAUNCH: begin
				div_start = 1'b1;
			end
			tdpt_pkg::ST_WAIT: begin
				div_start = 1'b0;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= tdpt_pkg::ST_IDLE;
			done_q           <= 1'b0;
			is_prime_q       <= 1'b0;
			held_candidate_q <= '0;
			trial_divisor_q  <= FIRST_DIVISOR;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (accept) begin
				held_candidate_q <= candidate;
				trial_divisor_q  <= FIRST_DIVISOR;
				if (trivial) begin
					// Two is the only even prime.
					done_q     <= 1'b1;
					is_prime_q <= (candidate == TWO);
				end
			end else if ((state_q == tdpt_pkg::ST_WAIT) && div_done) begin
				if (past_root) begin
					done_q          <= 1'b1;
					is_prime_q      <= 1'b1;
					trial_divisor_q <= FIRST_DIVISOR;
				end else if (divides) begin
					done_q          <= 1'b1;
					is_prime_q      <= 1'b0;
					trial_divisor_q <= FIRST_DIVISOR;
				end else begin
					trial_divisor_q <= trial_divisor_q + DIVISOR_STEP;
				end
			end
		end
	end

	assign done         = done_q;
	assign tested_value = held_candidate_q;
	assign is_prime     = is_prime_q;

endmodule

// File: sv/tdpt_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the trial-division primality tester, with their bind.
module tdpt_checker #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::TDPT_VALUE_WIDTH
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic [VALUE_WIDTH-1:0] candidate,
	input logic                   busy,
	input logic                   done,
	input logic [VALUE_WIDTH-1:0] tested_value,
	input logic                   is_prime
);

	localparam logic [VALUE_WIDTH-1:0] TWO = VALUE_WIDTH'(2);

	// An even candidate other than two is rejected on the next cycle.
	a_even_rejected: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !candidate[0] && (candidate != TWO))
		|=> (done && !is_prime && (tested_value == $past(candidate))))
	else $error("even candidate not rejected on the next cycle");

	// An odd candidate of three or more keeps the block busy.
	a_odd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && candidate[0] && (candidate != VALUE_WIDTH'(1)))
		|=> (busy && !done))
	else $error("odd candidate did not start a division run");

	// A result is only ever shown while the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
	else $error("result strobe while still busy");

	// A prime result is odd or is two.
	a_prime_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_prime) |-> (tested_value[0] || (tested_value == TWO)))
	else $error("even value other than two reported prime");

endmodule

bind trial_division_prime_test tdpt_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_tdpt_checker (.*);
